/* design/c1hwc_pkg.sv */
// Shared types, constants and helper functions for the C1HWC0 layout address generator.
package c1hwc_pkg;

  localparam int MAX_LANES  = 64;
  localparam int IDX_W      = 41;
  localparam int DIM_W      = 13;
  localparam int DIM_LIMIT  = 4096;
  localparam int N_W        = 16;
  localparam int C0_W       = 7;
  localparam int LANE_W     = 6;
  localparam int RC_W       = 12;
  localparam int HW_W       = 25;
  localparam int POS_W      = 24;
  localparam int POSN_W     = 40;
  localparam int BLKN_W     = 17;
  localparam int LOFF_W     = 30;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYOUT_MODE = 3'd0,
    REG_BATCH_COUNT = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_WIDTH       = 3'd3,
    REG_BLOCK_LANES = 3'd4
  } reg_index_t;

  typedef enum logic {
    LAYOUT_NCHW = 1'b0,
    LAYOUT_HWCN = 1'b1
  } layout_t;

  // Effective (already clamped) configuration plus the H*W plane size.
  typedef struct packed {
    logic              layout_mode;
    logic [N_W-1:0]    n_dim;
    logic [DIM_W-1:0]  h_dim;
    logic [DIM_W-1:0]  w_dim;
    logic [C0_W-1:0]   c0;
    logic [HW_W-1:0]   hw;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] dst_index;
    logic [IDX_W-1:0] src_index;
    logic             pad;
    logic             last;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_LIMIT)) begin
      r = DIM_W'(DIM_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [C0_W-1:0] clamp_lanes(input logic [C0_W-1:0] v);
    logic [C0_W-1:0] r;
    if (v == '0) begin
      r = C0_W'(1);
    end else if (v > C0_W'(MAX_LANES)) begin
      r = C0_W'(MAX_LANES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [N_W-1:0] clamp_batch(input logic [N_W-1:0] v);
    return (v == '0) ? N_W'(1) : v;
  endfunction

endpackage

/* design/c1hwc_cfg_regs.sv */
// Configuration register file: clamps each dimension on write and keeps the H*W product.
module c1hwc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [c1hwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c1hwc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output c1hwc_pkg::cfg_t                      cfg
);
  import c1hwc_pkg::*;

  cfg_t             regs;
  logic [DIM_W-1:0] new_dim;

  assign new_dim = clamp_dim(cfg_data[DIM_W-1:0]);

  // The plane size is refreshed in the same edge as the dimension it depends on.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.layout_mode <= LAYOUT_NCHW;
      regs.n_dim       <= N_W'(1);
      regs.h_dim       <= DIM_W'(1);
      regs.w_dim       <= DIM_W'(1);
      regs.c0          <= C0_W'(16);
      regs.hw          <= HW_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LAYOUT_MODE: regs.layout_mode <= cfg_data[0];
        REG_BATCH_COUNT: regs.n_dim <= clamp_batch(cfg_data[N_W-1:0]);
        REG_HEIGHT: begin
          regs.h_dim <= new_dim;
          regs.hw    <= HW_W'(new_dim) * HW_W'(regs.w_dim);
        end
        REG_WIDTH: begin
          regs.w_dim <= new_dim;
          regs.hw    <= HW_W'(regs.h_dim) * HW_W'(new_dim);
        end
        REG_BLOCK_LANES: regs.c0 <= clamp_lanes(cfg_data[C0_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* design/c1hwc_walk.sv */
// Position walker: running counters and index accumulators for the block, row, column, lane walk.
module c1hwc_walk (
  input  logic                 clk,
  input  logic                 rst,
  input  c1hwc_pkg::cfg_t      cfg,
  input  logic                 rewind,
  input  logic                 step,
  input  logic                 item_restart,
  output c1hwc_pkg::result_t   res
);
  import c1hwc_pkg::*;

  logic [LANE_W-1:0] lane, lane_next, cur_lane;
  logic [RC_W-1:0]   col, col_next, cur_col;
  logic [RC_W-1:0]   row, row_next, cur_row;
  logic [BLKN_W-1:0] blk_n, blk_n_next, cur_blk_n;
  logic [IDX_W-1:0]  dst, dst_next, cur_dst;
  logic [LOFF_W-1:0] lane_off, lane_off_next, cur_lane_off;
  logic [IDX_W-1:0]  blk_base, blk_base_next, cur_blk_base;
  logic [POS_W-1:0]  pos, pos_next, cur_pos;
  logic [POSN_W-1:0] pos_n, pos_n_next, cur_pos_n;

  logic [BLKN_W-1:0] n;
  logic              pad, lane_end, col_end, row_end, blk_end, last;
  logic [IDX_W-1:0]  src_nchw, src_hwcn;

  // A restart on the item itself makes this beat start from the first position.
  always_comb begin
    cur_lane     = item_restart ? '0 : lane;
    cur_col      = item_restart ? '0 : col;
    cur_row      = item_restart ? '0 : row;
    cur_blk_n    = item_restart ? '0 : blk_n;
    cur_dst      = item_restart ? '0 : dst;
    cur_lane_off = item_restart ? '0 : lane_off;
    cur_blk_base = item_restart ? '0 : blk_base;
    cur_pos      = item_restart ? '0 : pos;
    cur_pos_n    = item_restart ? '0 : pos_n;
  end

  always_comb begin
    n        = cur_blk_n + BLKN_W'(cur_lane);
    pad      = n >= BLKN_W'(cfg.n_dim);
    lane_end = (C0_W'(cur_lane) + C0_W'(1)) == cfg.c0;
    col_end  = (DIM_W'(cur_col) + DIM_W'(1)) == cfg.w_dim;
    row_end  = (DIM_W'(cur_row) + DIM_W'(1)) == cfg.h_dim;
    blk_end  = (cur_blk_n + BLKN_W'(cfg.c0)) >= BLKN_W'(cfg.n_dim);
    last     = lane_end && col_end && row_end && blk_end;

    // NCHW: n*HW + h*W + w, with n*HW split into block base and lane offset.
    src_nchw = cur_blk_base + IDX_W'(cur_lane_off) + IDX_W'(cur_pos);
    // HWCN: (h*W + w)*N + n.
    src_hwcn = IDX_W'(cur_pos_n) + IDX_W'(n);

    res.dst_index = cur_dst;
    res.pad       = pad;
    res.last      = last;
    if (pad) begin
      res.src_index = '0;
    end else if (cfg.layout_mode == LAYOUT_HWCN) begin
      res.src_index = src_hwcn;
    end else begin
      res.src_index = src_nchw;
    end
  end

  always_comb begin
    lane_next     = cur_lane + LANE_W'(1);
    lane_off_next = cur_lane_off + LOFF_W'(cfg.hw);
    col_next      = cur_col;
    row_next      = cur_row;
    pos_next      = cur_pos;
    pos_n_next    = cur_pos_n;
    blk_n_next    = cur_blk_n;
    blk_base_next = cur_blk_base;
    dst_next      = last ? '0 : cur_dst + IDX_W'(1);
    if (lane_end) begin
      lane_next     = '0;
      lane_off_next = '0;
      col_next      = col_end ? '0 : cur_col + RC_W'(1);
      if (col_end && row_end) begin
        pos_next   = '0;
        pos_n_next = '0;
      end else begin
        pos_next   = cur_pos + POS_W'(1);
        pos_n_next = cur_pos_n + POSN_W'(cfg.n_dim);
      end
      if (col_end) begin
        row_next = row_end ? '0 : cur_row + RC_W'(1);
      end
      if (col_end && row_end) begin
        if (blk_end) begin
          blk_n_next    = '0;
          blk_base_next = '0;
        end else begin
          blk_n_next    = cur_blk_n + BLKN_W'(cfg.c0);
          // The last lane offset is (C0-1)*HW, so one more plane gives C0*HW.
          blk_base_next = cur_blk_base + IDX_W'(cur_lane_off) + IDX_W'(cfg.hw);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rewind) begin
      lane     <= '0;
      col      <= '0;
      row      <= '0;
      blk_n    <= '0;
      dst      <= '0;
      lane_off <= '0;
      blk_base <= '0;
      pos      <= '0;
      pos_n    <= '0;
    end else if (step) begin
      lane     <= lane_next;
      col      <= col_next;
      row      <= row_next;
      blk_n    <= blk_n_next;
      dst      <= dst_next;
      lane_off <= lane_off_next;
      blk_base <= blk_base_next;
      pos      <= pos_next;
      pos_n    <= pos_n_next;
    end
  end

endmodule

/* design/c1hwc0_layout_address_generator_unit.sv */
// Top level of the C1HWC0 layout address generator: input register, walker and result register.
// Path: an accepted item beat is held in the input register, then goes through the walker into the result register.
// Throughput: one item beat per cycle, set by the walker step between the
// input register and the result register; stalls pass back only while both hold a beat.
// Reset: synchronous and active high; registers return to their documented defaults and the
// walk returns to the first destination position. Any configuration write also rewinds it.
module c1hwc0_layout_address_generator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [c1hwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c1hwc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 restart,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [c1hwc_pkg::IDX_W-1:0]          dst_index,
  output logic [c1hwc_pkg::IDX_W-1:0]          src_index,
  output logic                                 pad,
  output logic                                 last
);
  import c1hwc_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_beat;
  logic    in_valid, in_restart;
  logic    out_valid;
  logic    out_free;
  logic    step;

  c1hwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register is free when it is empty or its beat leaves this cycle.
  // The input register then hands its beat to the walker, which both forms the
  // result and advances the walk in that same cycle.
  assign out_free   = !out_valid || !result_stall;
  assign step       = in_valid && out_free;
  assign item_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_restart <= restart;
    end
  end

  // The user must write the configuration only with the block idle (the block itself
  // does not enforce this), so that rewinding the walker never collides with a beat in flight.
  c1hwc_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rewind       (cfg_write),
    .step         (step),
    .item_restart (in_restart),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_beat <= res;
    end
  end

  assign result_valid = out_valid;
  assign dst_index    = out_beat.dst_index;
  assign src_index    = out_beat.src_index;
  assign pad          = out_beat.pad;
  assign last         = out_beat.last;

endmodule

/* design/c1hwc_checker.sv */
// Port-level checker for the C1HWC0 layout address generator and its bind statement.
module c1hwc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic [c1hwc_pkg::IDX_W-1:0]          dst_index,
  input logic [c1hwc_pkg::IDX_W-1:0]          src_index,
  input logic                                 pad,
  input logic                                 last
);
  import c1hwc_pkg::*;

  // A padded position never carries a source address.
  a_pad_src_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && pad |-> src_index == '0)
    else $error("padded beat with nonzero source index");

  // The first destination position is lane zero of block zero, always a real element.
  a_first_not_pad: assert property (@(posedge clk) disable iff (rst)
    result_valid && dst_index == '0 |-> !pad)
    else $error("first position flagged as pad");

  // Input backpressure only happens while a result beat is waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with empty result register");

  // A stalled result beat stays and holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(dst_index)
      && $stable(src_index) && $stable(pad) && $stable(last))
    else $error("stalled result beat changed");

endmodule

bind c1hwc0_layout_address_generator_unit c1hwc_checker u_c1hwc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .dst_index    (dst_index),
  .src_index    (src_index),
  .pad          (pad),
  .last         (last)
);
